@@ hw/rtl/dioe_pkg.sv @@
// Shared types, codes and helpers for the digital I/O event node.
// No dependencies; imported by dioe_pin_store and digital_io_event_node.
package dioe_pkg;

    localparam int DEF_NUM_INPUTS  = 8;
    localparam int DEF_NUM_OUTPUTS = 8;
    localparam int MAX_RES         = 16;
    localparam int SAMPLE_W        = 8;

    // item kinds
    localparam logic [1:0] KIND_SCAN  = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_WRITE = 2'd2;

    // result kinds
    localparam logic [1:0] RES_EVENT = 2'd0;
    localparam logic [1:0] RES_READ  = 2'd1;
    localparam logic [1:0] RES_ACK   = 2'd2;

    // event types
    localparam logic [2:0] EV_NONE   = 3'd0;
    localparam logic [2:0] EV_BUTTON = 3'd0;
    localparam logic [2:0] EV_ON     = 3'd1;
    localparam logic [2:0] EV_OFF    = 3'd2;
    localparam logic [2:0] EV_OPENED = 3'd3;
    localparam logic [2:0] EV_CLOSED = 3'd4;

    // register map regions
    localparam logic [2:0] RG_IN_LEVEL  = 3'd0;
    localparam logic [2:0] RG_IN_FLAGS  = 3'd1;
    localparam logic [2:0] RG_IN_ZONE   = 3'd2;
    localparam logic [2:0] RG_IN_SUB    = 3'd3;
    localparam logic [2:0] RG_OUT_LEVEL = 3'd4;
    localparam logic [2:0] RG_OUT_FLAGS = 3'd5;
    localparam logic [2:0] RG_OUT_SUB   = 3'd6;
    localparam logic [2:0] RG_NONE      = 3'd7;

    // bit positions in the flag bytes of the register map
    localparam int B_LVL  = 0;
    localparam int B_INV  = 1;
    localparam int B_DOOR = 4;
    localparam int B_OFF  = 5;
    localparam int B_ON   = 6;
    localparam int B_BTN  = 7;

    // bit positions in stored input flags
    localparam int FI_INV  = 0;
    localparam int FI_DOOR = 1;
    localparam int FI_OFF  = 2;
    localparam int FI_ON   = 3;
    localparam int FI_BTN  = 4;

    // bit positions in stored output flags
    localparam int FO_INV = 0;
    localparam int FO_OFF = 1;
    localparam int FO_ON  = 2;

    localparam logic [4:0] IN_FLAGS_RST  = 5'b11101;
    localparam logic [2:0] OUT_FLAGS_RST = 3'b110;
    localparam logic [7:0] ZONE_RST      = 8'h00;

    typedef struct packed {
        logic       level;
        logic [4:0] flags;
        logic [7:0] zone;
        logic [7:0] subzone;
    } in_ent_t;

    typedef struct packed {
        logic       level;
        logic [2:0] flags;
        logic [7:0] subzone;
    } out_ent_t;

    typedef struct packed {
        logic [1:0] kind_res;
        logic [7:0] pin_drive;
        logic [7:0] read_data;
        logic [7:0] event_subzone;
        logic [7:0] event_zone;
        logic       event_data;
        logic [2:0] event_type;
    } res_t;

    function automatic int idx_w(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

    function automatic logic [4:0] in_flags_from_byte(input logic [7:0] b);
        logic [4:0] f;
        f          = '0;
        f[FI_INV]  = b[B_INV];
        f[FI_DOOR] = b[B_DOOR];
        f[FI_OFF]  = b[B_OFF];
        f[FI_ON]   = b[B_ON];
        f[FI_BTN]  = b[B_BTN];
        return f;
    endfunction

    function automatic logic [7:0] in_flags_to_byte(input logic [4:0] f);
        logic [7:0] b;
        b         = '0;
        b[B_INV]  = f[FI_INV];
        b[B_DOOR] = f[FI_DOOR];
        b[B_OFF]  = f[FI_OFF];
        b[B_ON]   = f[FI_ON];
        b[B_BTN]  = f[FI_BTN];
        return b;
    endfunction

    function automatic logic [2:0] out_flags_from_byte(input logic [7:0] b);
        logic [2:0] f;
        f         = '0;
        f[FO_INV] = b[B_INV];
        f[FO_OFF] = b[B_OFF];
        f[FO_ON]  = b[B_ON];
        return f;
    endfunction

    // invert bit is not reported on reads
    function automatic logic [7:0] out_read_byte(input logic lvl, input logic [2:0] f);
        logic [7:0] b;
        b        = '0;
        b[B_LVL] = lvl;
        b[B_OFF] = f[FO_OFF];
        b[B_ON]  = f[FO_ON];
        return b;
    endfunction

    function automatic res_t mk_res(input logic [1:0] kr, input logic [2:0] et,
                                    input logic ed, input logic [7:0] ez,
                                    input logic [7:0] es, input logic [7:0] rd,
                                    input logic [7:0] drv);
        res_t r;
        r.kind_res      = kr;
        r.event_type    = et;
        r.event_data    = ed;
        r.event_zone    = ez;
        r.event_subzone = es;
        r.read_data     = rd;
        r.pin_drive     = drv;
        return r;
    endfunction

endpackage

@@ hw/rtl/digital_io_event_node.sv @@
// Digital I/O event node: top level, item sequencer and result stream.
// Each pin costs a memory read, an evaluate step, a check step and one put step per event.
// One item at a time; the next item is taken while the last result waits; a busy
// result port stalls the put and flush steps.
// Reset (aresetn, synchronous) clears control, drive levels and entry valid bits.
module digital_io_event_node
    import dioe_pkg::*;
#(
    parameter int NUM_INPUTS  = DEF_NUM_INPUTS,
    parameter int NUM_OUTPUTS = DEF_NUM_OUTPUTS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // pin_samples, reg_address, write_data
    input  logic [1:0]  s_axis_tuser,   // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // event_type, event_data, event_zone, event_subzone, read_data, pin_drive
    output logic [39:0] m_axis_tdata,
    output logic [1:0]  m_axis_tuser,   // kind_res
    output logic        m_axis_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);

    localparam int IIW = idx_w(NUM_INPUTS);
    localparam int OIW = idx_w(NUM_OUTPUTS);
    localparam int XW  = (IIW > OIW) ? IIW : OIW;
    localparam int CW  = $clog2(MAX_RES + 1);

    localparam logic [7:0] A_IF  = 8'(NUM_INPUTS);
    localparam logic [7:0] A_IZ  = 8'(2 * NUM_INPUTS);
    localparam logic [7:0] A_IS  = 8'(3 * NUM_INPUTS);
    localparam logic [7:0] A_OL  = 8'(4 * NUM_INPUTS);
    localparam logic [7:0] A_OF  = 8'(4 * NUM_INPUTS + NUM_OUTPUTS);
    localparam logic [7:0] A_OS  = 8'(4 * NUM_INPUTS + 2 * NUM_OUTPUTS);
    localparam logic [7:0] A_END = 8'(4 * NUM_INPUTS + 3 * NUM_OUTPUTS);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RD    = 3'd1;
    localparam logic [2:0] S_EVAL  = 3'd2;
    localparam logic [2:0] S_PUT   = 3'd3;
    localparam logic [2:0] S_FLUSH = 3'd4;

    logic [2:0]             state_reg, state_next;
    logic [1:0]             op_reg, op_next;
    logic [7:0]             samp_reg, samp_next;
    logic [7:0]             wdat_reg, wdat_next;
    logic [2:0]             rgn_reg, rgn_next;
    logic [XW-1:0]          idx_reg, idx_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic                   pa_v_reg, pa_v_next;
    res_t                   pa_reg, pa_next;
    logic                   pb_v_reg, pb_v_next;
    res_t                   pb_reg, pb_next;
    logic                   pend_v_reg, pend_v_next;
    res_t                   pend_reg, pend_next;
    logic                   mv_reg, mv_next;
    res_t                   mres_reg, mres_next;
    logic                   mlast_reg, mlast_next;
    logic [NUM_OUTPUTS-1:0] drive_reg, drive_next;
    logic [7:0]             zone_reg, zone_next;

    logic                   in_we;
    in_ent_t                in_wdata;
    in_ent_t                in_rd;
    logic                   out_we;
    out_ent_t               out_wdata;
    out_ent_t               out_rd;

    logic [7:0]             a8;
    logic [2:0]             dec_rgn;
    logic [7:0]             dec_base;
    logic                   out_free;
    logic                   s_fire;

    dioe_pin_store #(
        .NUM_INPUTS  (NUM_INPUTS),
        .NUM_OUTPUTS (NUM_OUTPUTS)
    ) u_store (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_rd_idx   (idx_reg[IIW-1:0]),
        .in_wr_en    (in_we),
        .in_wr_idx   (idx_reg[IIW-1:0]),
        .in_wr_data  (in_wdata),
        .in_rd_data  (in_rd),
        .out_rd_idx  (idx_reg[OIW-1:0]),
        .out_wr_en   (out_we),
        .out_wr_idx  (idx_reg[OIW-1:0]),
        .out_wr_data (out_wdata),
        .out_rd_data (out_rd)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !mv_reg || m_axis_tready;
    assign cfg_ready     = 1'b1;

    assign m_axis_tvalid = mv_reg;
    assign m_axis_tuser  = mres_reg.kind_res;
    assign m_axis_tlast  = mlast_reg;
    assign m_axis_tdata  = {4'b0, mres_reg.pin_drive, mres_reg.read_data,
                            mres_reg.event_subzone, mres_reg.event_zone,
                            mres_reg.event_data, mres_reg.event_type};

    // address decode
    always_comb begin
        a8 = {1'b0, s_axis_tdata[14:8]};
        if (a8 < A_IF) begin
            dec_rgn = RG_IN_LEVEL;  dec_base = 8'd0;
        end else if (a8 < A_IZ) begin
            dec_rgn = RG_IN_FLAGS;  dec_base = A_IF;
        end else if (a8 < A_IS) begin
            dec_rgn = RG_IN_ZONE;   dec_base = A_IZ;
        end else if (a8 < A_OL) begin
            dec_rgn = RG_IN_SUB;    dec_base = A_IS;
        end else if (a8 < A_OF) begin
            dec_rgn = RG_OUT_LEVEL; dec_base = A_OL;
        end else if (a8 < A_OS) begin
            dec_rgn = RG_OUT_FLAGS; dec_base = A_OF;
        end else if (a8 < A_END) begin
            dec_rgn = RG_OUT_SUB;   dec_base = A_OS;
        end else begin
            dec_rgn = RG_NONE;      dec_base = 8'd0;
        end
    end

    always_comb begin
        logic [7:0] pin8;
        logic       raw;
        logic       ns;
        logic       lvl;
        logic [2:0] oflags;
        logic [7:0] rdval;
        res_t       put_res;

        state_next  = state_reg;
        op_next     = op_reg;
        samp_next   = samp_reg;
        wdat_next   = wdat_reg;
        rgn_next    = rgn_reg;
        idx_next    = idx_reg;
        cnt_next    = cnt_reg;
        pa_v_next   = pa_v_reg;
        pa_next     = pa_reg;
        pb_v_next   = pb_v_reg;
        pb_next     = pb_reg;
        pend_v_next = pend_v_reg;
        pend_next   = pend_reg;
        mv_next     = mv_reg;
        mres_next   = mres_reg;
        mlast_next  = mlast_reg;
        drive_next  = drive_reg;
        zone_next   = zone_reg;
        in_we       = 1'b0;
        in_wdata    = in_rd;
        out_we      = 1'b0;
        out_wdata   = out_rd;
        pin8        = 8'(idx_reg);
        raw         = 1'b0;
        ns          = 1'b0;
        lvl         = wdat_reg[B_LVL];
        oflags      = out_rd.flags;
        rdval       = 8'd0;
        put_res     = pa_v_reg ? pa_reg : pb_reg;

        if (cfg_valid) begin
            zone_next = cfg_data;
        end

        if (mv_reg && m_axis_tready) begin
            mv_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    if (s_axis_tuser == KIND_SCAN || s_axis_tuser == KIND_READ ||
                        s_axis_tuser == KIND_WRITE) begin
                        op_next    = s_axis_tuser;
                        samp_next  = s_axis_tdata[7:0];
                        wdat_next  = s_axis_tdata[22:15];
                        rgn_next   = dec_rgn;
                        idx_next   = (s_axis_tuser == KIND_SCAN) ? '0
                                                                 : XW'(a8 - dec_base);
                        cnt_next   = '0;
                        state_next = S_RD;
                    end
                end
            end
            S_RD: begin
                state_next = S_EVAL;
            end
            S_EVAL: begin
                pa_v_next  = 1'b0;
                pb_v_next  = 1'b0;
                state_next = S_PUT;
                case (op_reg)
                    KIND_SCAN: begin
                        raw = (pin8 < 8'(SAMPLE_W)) ? samp_reg[pin8[2:0]] : 1'b0;
                        ns  = raw ^ in_rd.flags[FI_INV];
                        if (ns != in_rd.level) begin
                            in_we          = 1'b1;
                            in_wdata.level = ns;
                            pa_v_next      = in_rd.flags[FI_BTN];
                            pa_next = mk_res(RES_EVENT, EV_BUTTON, ns, in_rd.zone,
                                             in_rd.subzone, 8'd0, 8'(drive_reg));
                            pb_v_next = ns ? in_rd.flags[FI_ON] : in_rd.flags[FI_OFF];
                            pb_next = mk_res(RES_EVENT,
                                             in_rd.flags[FI_DOOR]
                                                 ? (ns ? EV_OPENED : EV_CLOSED)
                                                 : (ns ? EV_ON : EV_OFF),
                                             1'b0, in_rd.zone, in_rd.subzone, 8'd0,
                                             8'(drive_reg));
                        end
                    end
                    KIND_READ: begin
                        case (rgn_reg)
                            RG_IN_LEVEL:  rdval = {7'd0, in_rd.level};
                            RG_IN_FLAGS:  rdval = in_flags_to_byte(in_rd.flags);
                            RG_IN_ZONE:   rdval = in_rd.zone;
                            RG_IN_SUB:    rdval = in_rd.subzone;
                            RG_OUT_LEVEL: rdval = {7'd0, out_rd.level};
                            RG_OUT_FLAGS: rdval = out_read_byte(out_rd.level, out_rd.flags);
                            RG_OUT_SUB:   rdval = out_rd.subzone;
                            default:      rdval = 8'd0;
                        endcase
                        pa_v_next = 1'b1;
                        pa_next   = mk_res(RES_READ, EV_NONE, 1'b0, 8'd0, 8'd0, rdval,
                                           8'(drive_reg));
                    end
                    default: begin
                        case (rgn_reg)
                            RG_IN_FLAGS: begin
                                in_we          = 1'b1;
                                in_wdata.flags = in_flags_from_byte(wdat_reg);
                            end
                            RG_IN_ZONE: begin
                                in_we         = 1'b1;
                                in_wdata.zone = wdat_reg;
                            end
                            RG_IN_SUB: begin
                                in_we            = 1'b1;
                                in_wdata.subzone = wdat_reg;
                            end
                            RG_OUT_LEVEL, RG_OUT_FLAGS: begin
                                if (rgn_reg == RG_OUT_FLAGS) begin
                                    oflags = out_flags_from_byte(wdat_reg);
                                end
                                out_we          = 1'b1;
                                out_wdata.level = lvl;
                                out_wdata.flags = oflags;
                                drive_next[idx_reg[OIW-1:0]] = lvl ^ oflags[FO_INV];
                                pa_v_next = (lvl != out_rd.level) &&
                                            (lvl ? oflags[FO_ON] : oflags[FO_OFF]);
                            end
                            RG_OUT_SUB: begin
                                out_we            = 1'b1;
                                out_wdata.subzone = wdat_reg;
                            end
                            default: begin
                            end
                        endcase
                        pa_next   = mk_res(RES_EVENT, lvl ? EV_ON : EV_OFF, 1'b0, zone_reg,
                                           out_rd.subzone, 8'd0, 8'(drive_next));
                        pb_v_next = 1'b1;
                        pb_next   = mk_res(RES_ACK, EV_NONE, 1'b0, 8'd0, 8'd0, 8'd0,
                                           8'(drive_next));
                    end
                endcase
            end
            S_PUT: begin
                if (pa_v_reg || pb_v_reg) begin
                    if (cnt_reg >= CW'(MAX_RES)) begin
                        if (pa_v_reg) pa_v_next = 1'b0;
                        else          pb_v_next = 1'b0;
                    end else if (!pend_v_reg || out_free) begin
                        if (pa_v_reg) pa_v_next = 1'b0;
                        else          pb_v_next = 1'b0;
                        if (pend_v_reg) begin
                            mv_next    = 1'b1;
                            mres_next  = pend_reg;
                            mlast_next = 1'b0;
                        end
                        pend_v_next = 1'b1;
                        pend_next   = put_res;
                        cnt_next    = cnt_reg + CW'(1);
                    end
                end else if (op_reg == KIND_SCAN && idx_reg != XW'(NUM_INPUTS - 1)) begin
                    idx_next   = idx_reg + XW'(1);
                    state_next = S_RD;
                end else begin
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (!pend_v_reg) begin
                    state_next = S_IDLE;
                end else if (out_free) begin
                    mv_next     = 1'b1;
                    mres_next   = pend_reg;
                    mlast_next  = 1'b1;
                    pend_v_next = 1'b0;
                    state_next  = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            pa_v_reg   <= 1'b0;
            pb_v_reg   <= 1'b0;
            pend_v_reg <= 1'b0;
            mv_reg     <= 1'b0;
            drive_reg  <= '0;
            zone_reg   <= ZONE_RST;
        end else begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            pa_v_reg   <= pa_v_next;
            pb_v_reg   <= pb_v_next;
            pend_v_reg <= pend_v_next;
            mv_reg     <= mv_next;
            drive_reg  <= drive_next;
            zone_reg   <= zone_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg    <= op_next;
        samp_reg  <= samp_next;
        wdat_reg  <= wdat_next;
        rgn_reg   <= rgn_next;
        idx_reg   <= idx_next;
        pa_reg    <= pa_next;
        pb_reg    <= pb_next;
        pend_reg  <= pend_next;
        mres_reg  <= mres_next;
        mlast_reg <= mlast_next;
    end

endmodule

@@ hw/rtl/dioe_pin_store.sv @@
// Per-pin state memories (input and output entries) with a registered read port.
// Entries never written read back as their reset values. Uses dioe_pkg.
module dioe_pin_store
    import dioe_pkg::*;
#(
    parameter int NUM_INPUTS  = DEF_NUM_INPUTS,
    parameter int NUM_OUTPUTS = DEF_NUM_OUTPUTS
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic [idx_w(NUM_INPUTS)-1:0]     in_rd_idx,
    input  logic                             in_wr_en,
    input  logic [idx_w(NUM_INPUTS)-1:0]     in_wr_idx,
    input  in_ent_t                          in_wr_data,
    output in_ent_t                          in_rd_data,
    input  logic [idx_w(NUM_OUTPUTS)-1:0]    out_rd_idx,
    input  logic                             out_wr_en,
    input  logic [idx_w(NUM_OUTPUTS)-1:0]    out_wr_idx,
    input  out_ent_t                         out_wr_data,
    output out_ent_t                         out_rd_data
);

    localparam int IIW = idx_w(NUM_INPUTS);
    localparam int OIW = idx_w(NUM_OUTPUTS);

    in_ent_t                  in_mem_reg [NUM_INPUTS];
    logic [NUM_INPUTS-1:0]    in_vld_reg;
    in_ent_t                  in_q_reg;
    logic                     in_q_vld_reg;
    logic [IIW-1:0]           in_q_idx_reg;

    out_ent_t                 out_mem_reg [NUM_OUTPUTS];
    logic [NUM_OUTPUTS-1:0]   out_vld_reg;
    out_ent_t                 out_q_reg;
    logic                     out_q_vld_reg;
    logic [OIW-1:0]           out_q_idx_reg;

    always_ff @(posedge aclk) begin
        if (in_wr_en) begin
            in_mem_reg[in_wr_idx] <= in_wr_data;
        end
        in_q_reg     <= in_mem_reg[in_rd_idx];
        in_q_idx_reg <= in_rd_idx;
        if (out_wr_en) begin
            out_mem_reg[out_wr_idx] <= out_wr_data;
        end
        out_q_reg     <= out_mem_reg[out_rd_idx];
        out_q_idx_reg <= out_rd_idx;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg    <= '0;
            out_vld_reg   <= '0;
            in_q_vld_reg  <= 1'b0;
            out_q_vld_reg <= 1'b0;
        end else begin
            if (in_wr_en) begin
                in_vld_reg[in_wr_idx] <= 1'b1;
            end
            if (out_wr_en) begin
                out_vld_reg[out_wr_idx] <= 1'b1;
            end
            in_q_vld_reg  <= in_vld_reg[in_rd_idx];
            out_q_vld_reg <= out_vld_reg[out_rd_idx];
        end
    end

    always_comb begin
        if (in_q_vld_reg) begin
            in_rd_data = in_q_reg;
        end else begin
            in_rd_data.level   = 1'b0;
            in_rd_data.flags   = IN_FLAGS_RST;
            in_rd_data.zone    = ZONE_RST;
            in_rd_data.subzone = 8'(in_q_idx_reg) + 8'd1;
        end
        if (out_q_vld_reg) begin
            out_rd_data = out_q_reg;
        end else begin
            out_rd_data.level   = 1'b0;
            out_rd_data.flags   = OUT_FLAGS_RST;
            out_rd_data.subzone = 8'(out_q_idx_reg) + 8'd1;
        end
    end

endmodule
